>>> hw/rtl/twg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twg_pkg
// Shared types, register codes and the quarter-wave table generator for the
// multichannel test waveform generator.
// ----------------------------------------------------------------------------
package twg_pkg;

    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int SAMPLE_W  = 12;
    localparam int TIME_W    = 32;
    localparam int PHASE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int SEL_W     = 3;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_RATE   = 2'd0,
        CFG_WAVE_SELECT  = 2'd1,
        CFG_INVERT_MASK  = 2'd2,
        CFG_LEVEL_OFFSET = 2'd3
    } cfg_reg_t;

    typedef enum logic [SEL_W-1:0] {
        WAVE_DC     = 3'd0,
        WAVE_SQUARE = 3'd1,
        WAVE_SAW    = 3'd2,
        WAVE_TRI    = 3'd3,
        WAVE_SINE   = 3'd4,
        WAVE_COSINE = 3'd5
    } wave_sel_t;

    typedef enum logic {
        ENG_IDLE,
        ENG_RUN
    } eng_state_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [LANE_W-1:0] lane;
        wave_sel_t         sel;
        logic              inv;
        logic [TIME_W-1:0] stamp;
    } twg_lane_ctl_t;

    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic [LANE_W-1:0]          lane;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]          stamp;
    } twg_lane_res_t;

    // one quarter-wave entry, Taylor series in Q30, scaled to 2048 full scale
    function automatic logic [SAMPLE_W-1:0] quarter_entry(input int unsigned k,
                                                         input int unsigned bits);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        a    = (HALF_PI_Q30 * 64'(k)) >> bits;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int n = 1; n <= 6; n++) begin
            unique case (n)
                1: term = (term * a2) / 64'd6;
                2: term = (term * a2) / 64'd20;
                3: term = (term * a2) / 64'd42;
                4: term = (term * a2) / 64'd72;
                5: term = (term * a2) / 64'd110;
                default: term = (term * a2) / 64'd156;
            endcase
            term = term >> 30;
            if (n[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ((sum * 2048) + (longint'(1) << 29)) >>> 30;
        if (v > 2048) begin
            v = 2048;
        end
        return SAMPLE_W'(v);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/twg_phase_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twg_phase_mem
// Phase accumulator store: one write and one registered read per cycle,
// write-through on a same-entry collision, entries read as zero until written.
// ----------------------------------------------------------------------------
module twg_phase_mem import twg_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [PHASE_W-1:0]                   rd_data,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [PHASE_W-1:0]                   wr_data
);

    logic [PHASE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic [PHASE_W-1:0] mem_q_reg;
    logic               vld_q_reg;
    logic               byp_reg;
    logic [PHASE_W-1:0] byp_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg    <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
            byp_reg   <= wr_en && (wr_addr == rd_addr);
        end
    end

    // fresh write data wins over the stale array word
    assign rd_data = byp_reg   ? byp_data_reg :
                     vld_q_reg ? mem_q_reg    : '0;

endmodule
`default_nettype wire

>>> hw/rtl/twg_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twg_sine_rom
// Quarter-wave sine table, 2^SINE_TABLE_BITS + 1 entries, registered read.
// ----------------------------------------------------------------------------
module twg_sine_rom import twg_pkg::*; #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic                       aclk,
    input  wire logic [SINE_TABLE_BITS:0]   rd_addr,
    output logic      [SAMPLE_W-1:0]        rd_data
);

    localparam int ENTRIES = (1 << SINE_TABLE_BITS) + 1;

    logic [SAMPLE_W-1:0] rom_tab [ENTRIES];
    logic [SAMPLE_W-1:0] rd_data_reg;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
        localparam logic [SAMPLE_W-1:0] ENTRY = quarter_entry(k, SINE_TABLE_BITS);
        assign rom_tab[k] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_tab[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/twg_shaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twg_shaper
// Turns one channel phase into a sample: waveform select, table lookup,
// inversion, common offset and 12-bit saturation over two stages.
// ----------------------------------------------------------------------------
module twg_shaper import twg_pkg::*; #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [PHASE_W-1:0]         in_phase,
    input  wire twg_lane_ctl_t              in_ctl,
    input  wire logic signed [SAMPLE_W-1:0] level_offset,
    output twg_lane_res_t                   out_res
);

    localparam int RA_W = SINE_TABLE_BITS + 1;
    localparam logic [RA_W-1:0] QUARTER = RA_W'(1 << SINE_TABLE_BITS);

    twg_lane_ctl_t               p2_ctl_reg;
    logic [PHASE_W-1:0]          p2_phase_reg;
    twg_lane_ctl_t               p3_ctl_reg;
    logic signed [SAMPLE_W:0]    p3_wave_reg;
    logic                        p3_from_rom_reg;
    logic                        p3_neg_reg;

    logic [1:0]                  quad;
    logic [SINE_TABLE_BITS-1:0]  tab_idx;
    logic [RA_W-1:0]             rom_addr;
    logic [SAMPLE_W-1:0]         rom_data;
    logic signed [PHASE_W:0]     tri_t;
    logic signed [SAMPLE_W:0]    wave;
    logic                        from_rom;

    logic signed [SAMPLE_W:0]    rom_mag;
    logic signed [SAMPLE_W:0]    rom_val;
    logic signed [SAMPLE_W:0]    w_sel;
    logic signed [SAMPLE_W:0]    w_inv;
    logic signed [SAMPLE_W+1:0]  w_sum;
    logic signed [SAMPLE_W-1:0]  w_sat;

    // stage 2: phase in, table address and non-table waveforms
    always_ff @(posedge aclk) begin
        p2_phase_reg <= in_phase;
        if (!aresetn) begin
            p2_ctl_reg <= '0;
        end else begin
            p2_ctl_reg <= in_ctl;
        end
    end

    always_comb begin
        // cosine is the sine a quarter cycle on
        quad     = p2_phase_reg[PHASE_W-1 -: 2] + ((p2_ctl_reg.sel == WAVE_COSINE) ? 2'd1 : 2'd0);
        tab_idx  = p2_phase_reg[PHASE_W-3 -: SINE_TABLE_BITS];
        rom_addr = quad[0] ? (QUARTER - {1'b0, tab_idx}) : {1'b0, tab_idx};

        if (p2_phase_reg < 32'h4000_0000) begin
            tri_t = {1'b0, p2_phase_reg};
        end else if (p2_phase_reg < 32'hC000_0000) begin
            tri_t = 33'sh0_8000_0000 - $signed({1'b0, p2_phase_reg});
        end else begin
            tri_t = {1'b1, p2_phase_reg};
        end

        from_rom = 1'b0;
        unique case (p2_ctl_reg.sel)
            WAVE_DC:     wave = '0;
            WAVE_SQUARE: wave = p2_phase_reg[PHASE_W-1] ? -13'sd2048 : 13'sd2048;
            WAVE_SAW:    wave = {~p2_phase_reg[PHASE_W-1], ~p2_phase_reg[PHASE_W-1],
                                 p2_phase_reg[PHASE_W-2 -: SAMPLE_W-1]};
            WAVE_TRI:    wave = tri_t[PHASE_W-1 -: SAMPLE_W+1];
            WAVE_SINE, WAVE_COSINE: begin
                wave     = '0;
                from_rom = 1'b1;
            end
            default:     wave = '0;
        endcase
    end

    twg_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // stage 3: sign, inversion, offset, clamp
    always_ff @(posedge aclk) begin
        p3_wave_reg     <= wave;
        p3_from_rom_reg <= from_rom;
        p3_neg_reg      <= quad[1];
        if (!aresetn) begin
            p3_ctl_reg <= '0;
        end else begin
            p3_ctl_reg <= p2_ctl_reg;
        end
    end

    always_comb begin
        rom_mag = {1'b0, rom_data};
        rom_val = p3_neg_reg ? -rom_mag : rom_mag;
        w_sel   = p3_from_rom_reg ? rom_val : p3_wave_reg;
        w_inv   = p3_ctl_reg.inv ? -w_sel : w_sel;
        w_sum   = {w_inv[SAMPLE_W], w_inv} + {{2{level_offset[SAMPLE_W-1]}}, level_offset};
        if (w_sum > 14'sd2047) begin
            w_sat = 12'sd2047;
        end else if (w_sum < -14'sd2048) begin
            w_sat = -12'sd2048;
        end else begin
            w_sat = w_sum[SAMPLE_W-1:0];
        end

        out_res.valid  = p3_ctl_reg.valid;
        out_res.last   = p3_ctl_reg.last;
        out_res.lane   = p3_ctl_reg.lane;
        out_res.sample = w_sat;
        out_res.stamp  = p3_ctl_reg.stamp;
    end

endmodule
`default_nettype wire

>>> hw/rtl/multichannel_test_waveform_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_test_waveform_generator_unit
// Eight-channel phase accumulator waveform generator driven by tick events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per tick event, carrying its absolute tick time.
//   m_ channel: one beat per input beat, the stamp and CHANNELS samples;
//     samples of unused channels read zero.
//   cfg_ channel: register writes, always ready; write only while no beat is
//     in flight.
// Issue: a new set starts right behind the last channel of the previous one
//   unless two sets are already in flight or waiting, so at most two sets
//   are in flight. Each channel takes one pass through the phase memory.
// The input takes a new beat into its holding register while earlier ones
//   are still at work or waiting at the output; a stalled receiver holds the
//   output register, one more finished set can wait behind it, then the
//   input stops taking beats.
// Reset: accumulators and previous tick time read zero, registers return to
//   their reset values, no beat is pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multichannel_test_waveform_generator_unit import twg_pkg::*; #(
    parameter int CHANNELS        = 8,
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [TIME_W-1:0]           s_tick_time,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [TIME_W-1:0]                m_stamp,
    output logic signed [SAMPLE_W-1:0]       m_chan0,
    output logic signed [SAMPLE_W-1:0]       m_chan1,
    output logic signed [SAMPLE_W-1:0]       m_chan2,
    output logic signed [SAMPLE_W-1:0]       m_chan3,
    output logic signed [SAMPLE_W-1:0]       m_chan4,
    output logic signed [SAMPLE_W-1:0]       m_chan5,
    output logic signed [SAMPLE_W-1:0]       m_chan6,
    output logic signed [SAMPLE_W-1:0]       m_chan7,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DAT_W-1:0]        cfg_data
);

    localparam int PM_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(CHANNELS - 1);

    // configuration
    logic [PHASE_W-1:0]          phase_rate_reg;
    logic [LANES*SEL_W-1:0]      wave_select_reg;
    logic [LANES-1:0]            invert_mask_reg;
    logic signed [SAMPLE_W-1:0]  level_offset_reg;

    // input holding register
    logic                        front_full_reg;
    logic                        front_full_next;
    logic [TIME_W-1:0]           front_elapsed_reg;
    logic [TIME_W-1:0]           front_stamp_reg;
    logic [TIME_W-1:0]           prev_time_reg;
    logic                        accept;

    // channel sequencer
    eng_state_t                  eng_state_reg;
    eng_state_t                  eng_state_next;
    logic [LANE_W-1:0]           lane_reg;
    logic [LANE_W-1:0]           lane_next;
    logic [PHASE_W-1:0]          delta_reg;
    logic [TIME_W-1:0]           run_stamp_reg;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;
    logic [2*PHASE_W-1:0]        mult_full;
    logic                        issue;
    logic                        last_issue;
    logic                        start_ok;
    logic                        start_fire;
    twg_lane_ctl_t               issue_ctl;

    // read-modify-write stage
    twg_lane_ctl_t               p1_ctl_reg;
    logic [PHASE_W-1:0]          p1_delta_reg;
    logic [PHASE_W-1:0]          pm_rd_data;
    logic [PHASE_W-1:0]          p1_sum;

    // result collection
    twg_lane_res_t               lane_res;
    logic signed [SAMPLE_W-1:0]  coll_lane_reg [LANES];
    logic [TIME_W-1:0]           coll_stamp_reg;
    logic                        coll_full_reg;
    logic                        coll_full_next;
    logic signed [SAMPLE_W-1:0]  out_lane_reg [LANES];
    logic [TIME_W-1:0]           out_stamp_reg;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic                        move;
    logic                        deliver;
    logic signed [SAMPLE_W-1:0]  chan_out [LANES];

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_rate_reg   <= 32'd4294967;
            wave_select_reg  <= 24'd3065480;
            invert_mask_reg  <= 8'd192;
            level_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PHASE_RATE:   phase_rate_reg   <= cfg_data[PHASE_W-1:0];
                CFG_WAVE_SELECT:  wave_select_reg  <= cfg_data[LANES*SEL_W-1:0];
                CFG_INVERT_MASK:  invert_mask_reg  <= cfg_data[LANES-1:0];
                CFG_LEVEL_OFFSET: level_offset_reg <= cfg_data[SAMPLE_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------- input
    assign s_ready = !front_full_reg || start_fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (accept) begin
            front_full_next = 1'b1;
        end else if (start_fire) begin
            front_full_next = 1'b0;
        end else begin
            front_full_next = front_full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_full_reg <= 1'b0;
            prev_time_reg  <= '0;
        end else begin
            front_full_reg <= front_full_next;
            if (accept) begin
                prev_time_reg <= s_tick_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            front_elapsed_reg <= s_tick_time - prev_time_reg;
            front_stamp_reg   <= s_tick_time;
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign issue      = (eng_state_reg == ENG_RUN);
    assign last_issue = issue && (lane_reg == LAST_LANE);
    // at most two sets in flight or waiting keeps the collector safe
    assign start_ok   = front_full_reg && (cnt_reg < 2'd2);
    assign start_fire = start_ok && ((eng_state_reg == ENG_IDLE) || last_issue);
    assign mult_full  = 64'(phase_rate_reg) * 64'(front_elapsed_reg);

    always_comb begin
        eng_state_next = eng_state_reg;
        lane_next      = lane_reg;
        unique case (eng_state_reg)
            ENG_IDLE: begin
                if (start_fire) begin
                    eng_state_next = ENG_RUN;
                    lane_next      = '0;
                end
            end
            ENG_RUN: begin
                if (lane_reg == LAST_LANE) begin
                    lane_next = '0;
                    if (!start_fire) begin
                        eng_state_next = ENG_IDLE;
                    end
                end else begin
                    lane_next = lane_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_state_reg <= ENG_IDLE;
            lane_reg      <= '0;
        end else begin
            eng_state_reg <= eng_state_next;
            lane_reg      <= lane_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_fire) begin
            delta_reg     <= mult_full[PHASE_W-1:0];
            run_stamp_reg <= front_stamp_reg;
        end
    end

    assign cnt_next = cnt_reg + (start_fire ? 2'd1 : 2'd0) - (deliver ? 2'd1 : 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        issue_ctl.valid = issue;
        issue_ctl.last  = last_issue;
        issue_ctl.lane  = lane_reg;
        issue_ctl.sel   = wave_sel_t'(wave_select_reg[SEL_W*lane_reg +: SEL_W]);
        issue_ctl.inv   = invert_mask_reg[lane_reg];
        issue_ctl.stamp = run_stamp_reg;
    end

    // ---------------------------------------------------------------- phase rmw
    always_ff @(posedge aclk) begin
        p1_delta_reg <= delta_reg;
        if (!aresetn) begin
            p1_ctl_reg <= '0;
        end else begin
            p1_ctl_reg <= issue_ctl;
        end
    end

    twg_phase_mem #(
        .DEPTH(CHANNELS)
    ) u_phase_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (lane_reg[PM_AW-1:0]),
        .rd_data (pm_rd_data),
        .wr_en   (p1_ctl_reg.valid),
        .wr_addr (p1_ctl_reg.lane[PM_AW-1:0]),
        .wr_data (p1_sum)
    );

    assign p1_sum = pm_rd_data + p1_delta_reg;

    twg_shaper #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_shaper (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_phase     (p1_sum),
        .in_ctl       (p1_ctl_reg),
        .level_offset (level_offset_reg),
        .out_res      (lane_res)
    );

    // ---------------------------------------------------------------- collect / output
    assign deliver = m_valid_reg && m_ready;
    assign move    = coll_full_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (lane_res.valid && lane_res.last) begin
            coll_full_next = 1'b1;
        end else if (move) begin
            coll_full_next = 1'b0;
        end else begin
            coll_full_next = coll_full_reg;
        end

        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coll_full_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            coll_full_reg <= coll_full_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_res.valid) begin
            coll_lane_reg[lane_res.lane] <= lane_res.sample;
            if (lane_res.last) begin
                coll_stamp_reg <= lane_res.stamp;
            end
        end
        if (move) begin
            out_lane_reg  <= coll_lane_reg;
            out_stamp_reg <= coll_stamp_reg;
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_chan
        assign chan_out[c] = (c < CHANNELS) ? out_lane_reg[c] : '0;
    end

    assign m_valid = m_valid_reg;
    assign m_stamp = out_stamp_reg;
    assign m_chan0 = chan_out[0];
    assign m_chan1 = chan_out[1];
    assign m_chan2 = chan_out[2];
    assign m_chan3 = chan_out[3];
    assign m_chan4 = chan_out[4];
    assign m_chan5 = chan_out[5];
    assign m_chan6 = chan_out[6];
    assign m_chan7 = chan_out[7];

endmodule
`default_nettype wire
